[sv/nbu_pkg.sv]
// Package with the types, codes and constants of the backpropagation neuron.
`default_nettype none
package nbu_pkg;

    localparam int FAN_IN_DEF    = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int SLOT_W        = 6;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [16:0] LEARN_RATE_RST = 17'd9830;
    localparam logic [16:0] MOMENTUM_RST   = 17'd32768;

    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        FUNC_FORWARD = 3'd0,
        FUNC_OUT_GRAD = 3'd1,
        FUNC_HID_GRAD = 3'd2,
        FUNC_UPDATE = 3'd3,
        FUNC_LOAD = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        KIND_OUTPUT = 2'd0,
        KIND_GRADIENT = 2'd1,
        KIND_WEIGHT = 2'd2
    } kind_t;

    typedef enum logic [0:0] {
        CFG_LEARN_RATE = 1'b0,
        CFG_MOMENTUM = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]         func;
        logic [5:0]         slot;
        logic signed [31:0] value;
        logic signed [31:0] link_weight;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [5:0]         out_slot;
        logic signed [31:0] result;
    } out_item_t;

    // Classified command handed from the front to the back part.
    typedef struct packed {
        func_t              op;
        logic [5:0]         slot;
        logic               slot_ok;
        logic signed [31:0] value;
        logic signed [31:0] link_weight;
        logic               last;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_ACC,
        ST_DIV,
        ST_SIG_DONE,
        ST_INV_SQ,
        ST_GRAD_MUL,
        ST_GRAD_DONE,
        ST_UPD_M2,
        ST_UPD_M3,
        ST_UPD_SUM,
        ST_EMIT
    } state_t;

    // Saturate a 64-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > $signed({{32{1'b0}}, S32_MAX}))
        begin
            r = $signed(S32_MAX);
        end
        else if (v < $signed({{32{1'b1}}, S32_MIN}))
        begin
            r = $signed(S32_MIN);
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[sv/nbu_front.sv]
// Front part: accepts input items, drops meaningless ones and queues commands.
`default_nettype none
module nbu_front #(
    parameter int FAN_IN = nbu_pkg::FAN_IN_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire nbu_pkg::in_item_t in_item,
    output logic                  cmd_valid,
    output nbu_pkg::cmd_t         cmd,
    input  wire logic             cmd_take
);
    import nbu_pkg::*;

    cmd_t       q_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       wr_en, rd_en, known;
    cmd_t       new_cmd;

    // Classify the incoming item.
    always_comb
    begin
        known = (in_item.func <= 3'(FUNC_LOAD));
        new_cmd.op = func_t'(in_item.func);
        new_cmd.slot = in_item.slot;
        new_cmd.slot_ok = ({26'd0, in_item.slot} < 32'(FAN_IN));
        new_cmd.value = in_item.value;
        new_cmd.link_weight = in_item.link_weight;
        new_cmd.last = in_item.last;
    end

    assign full = (cnt_reg == 2'(QUEUE_DEPTH));
    assign wr_en = push && !full && known;
    assign rd_en = cmd_take && (cnt_reg != 2'd0);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd = q_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(wr_en) - 2'(rd_en);
        end
    end
endmodule
`default_nettype wire

[sv/nbu_div.sv]
// Radix-2 restoring divider for unsigned 48-bit by 33-bit quotients.
`default_nettype none
module nbu_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [47:0] dividend,
    input  wire logic [32:0] divisor,
    output logic             done,
    output logic [47:0]      quotient
);
    logic [47:0] q_reg;
    logic [33:0] rem_reg;
    logic [32:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [33:0] shifted;
    logic [34:0] diff;

    assign shifted = {rem_reg[32:0], q_reg[47]};
    assign diff = {1'b0, shifted} - {2'b00, den_reg};
    assign done = done_reg;
    assign quotient = q_reg;

    // One quotient bit per cycle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[34])
            begin
                rem_reg <= diff[33:0];
                q_reg <= {q_reg[46:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg <= {q_reg[46:0], 1'b0};
            end
        end
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= 6'd47;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

[sv/nbu_back.sv]
// Back part: executes neuron commands with a shared multiplier and divider.
`default_nettype none
module nbu_back #(
    parameter int FAN_IN    = nbu_pkg::FAN_IN_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire nbu_pkg::cmd_t      cmd,
    output logic                    cmd_take,
    input  wire logic [16:0]        learn_rate,
    input  wire logic [16:0]        momentum,
    output logic                    res_valid,
    output nbu_pkg::out_item_t      res,
    input  wire logic               res_taken
);
    import nbu_pkg::*;

    localparam int FRAC_BITS = FRAC_BITS_DEF;
    localparam int AW = (FAN_IN > 1) ? $clog2(FAN_IN) : 1;
    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

    // Memories: weights, weight changes and last inputs, cleared after reset.
    logic signed [31:0] w_mem [FAN_IN];
    logic signed [31:0] d_mem [FAN_IN];
    logic signed [31:0] x_mem [FAN_IN];
    logic signed [31:0] w_rd_reg, d_rd_reg, x_rd_reg;

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic signed [31:0] acc_reg, acc_next;
    logic signed [31:0] act_reg, act_next;
    logic signed [31:0] grad_reg, grad_next;
    logic signed [31:0] ta_reg, ta_next;
    logic signed [31:0] tb_reg, tb_next;
    logic signed [31:0] prod_reg;
    logic signed [32:0] ma, mb, ma_reg, mb_reg;
    logic               mul_go, mul_go_reg;
    logic               sig_mode_reg, sig_mode_next;
    out_item_t          res_reg, res_next;
    logic               res_valid_reg, res_valid_next;
    logic [AW:0]        clr_reg;
    logic               clearing;
    logic               mem_wr, ld_wr;
    logic [AW-1:0]      addr;

    logic               div_start, div_done;
    logic [47:0]        div_dividend, div_q;
    logic [32:0]        div_divisor;
    logic signed [63:0] sabs;

    assign addr = AW'(cmd.slot);
    assign clearing = !clr_reg[AW];

    // Multiplier stage: product shifted with floor rounding, saturated.
    logic signed [65:0] full_prod;
    assign full_prod = ma_reg * mb_reg;
    always_ff @(posedge clk)
    begin
        if (mul_go)
        begin
            ma_reg <= ma;
            mb_reg <= mb;
        end
        if (mul_go_reg)
        begin
            prod_reg <= sat32(64'(full_prod >>> FRAC_BITS));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_go_reg <= 1'b0;
        end
        else
        begin
            mul_go_reg <= mul_go;
        end
    end

    nbu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Memory reads at dequeue; writes from the update path, load, forward inputs and clear.
    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            w_mem[clr_reg[AW-1:0]] <= '0;
            d_mem[clr_reg[AW-1:0]] <= '0;
            x_mem[clr_reg[AW-1:0]] <= '0;
        end
        else if (ld_wr)
        begin
            w_mem[addr] <= cmd.value;
            d_mem[addr] <= '0;
        end
        else if (mem_wr)
        begin
            w_mem[AW'(cmd_reg.slot)] <= ta_reg;
            d_mem[AW'(cmd_reg.slot)] <= tb_reg;
        end
        if (!clearing && cmd_take && cmd.op == FUNC_FORWARD && cmd.slot_ok)
        begin
            x_mem[addr] <= cmd.value;
        end
        // The read data is held for the whole command.
        if (cmd_take)
        begin
            w_rd_reg <= w_mem[addr];
            d_rd_reg <= d_mem[addr];
            x_rd_reg <= x_mem[addr];
        end
    end

    assign res_valid = res_valid_reg;
    assign res = res_reg;

    // Next state and datapath control.
    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        acc_next = acc_reg;
        act_next = act_reg;
        grad_next = grad_reg;
        ta_next = ta_reg;
        tb_next = tb_reg;
        sig_mode_next = sig_mode_reg;
        res_next = res_reg;
        res_valid_next = res_valid_reg && !res_taken;
        cmd_take = 1'b0;
        mul_go = 1'b0;
        ma = '0;
        mb = '0;
        mem_wr = 1'b0;
        ld_wr = 1'b0;
        div_start = 1'b0;
        div_dividend = '0;
        div_divisor = '0;
        sabs = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && !clearing && !res_valid_next)
                begin
                    cmd_take = 1'b1;
                    cmd_next = cmd;
                    unique case (cmd.op)
                        FUNC_LOAD:
                        begin
                            ld_wr = cmd.slot_ok;
                        end
                        FUNC_UPDATE:
                        begin
                            if (cmd.slot_ok)
                            begin
                                state_next = ST_MUL1;
                            end
                        end
                        FUNC_OUT_GRAD:
                        begin
                            ta_next = sat32(64'(cmd.value) - 64'(act_reg));
                            state_next = ST_INV_SQ;
                            sig_mode_next = 1'b0;
                        end
                        default:
                        begin
                            state_next = ST_MUL1;
                        end
                    endcase
                end
            end
            ST_MUL1:
            begin
                mul_go = 1'b1;
                unique case (cmd_reg.op)
                    FUNC_FORWARD:
                    begin
                        ma = cmd_reg.slot_ok ? 33'(cmd_reg.value) : '0;
                        mb = 33'(w_rd_reg);
                    end
                    FUNC_HID_GRAD:
                    begin
                        ma = 33'(cmd_reg.link_weight);
                        mb = 33'(cmd_reg.value);
                    end
                    default:
                    begin
                        ma = {16'd0, learn_rate};
                        mb = 33'(x_rd_reg);
                    end
                endcase
                state_next = (cmd_reg.op == FUNC_UPDATE) ? ST_UPD_M2 : ST_ACC;
            end
            ST_ACC:
            begin
                if (!mul_go_reg)
                begin
                    acc_next = sat32(64'(acc_reg) + 64'(prod_reg));
                    if (!cmd_reg.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (cmd_reg.op == FUNC_FORWARD)
                    begin
                        state_next = ST_DIV;
                        sig_mode_next = 1'b1;
                    end
                    else
                    begin
                        ta_next = acc_next;
                        acc_next = '0;
                        sig_mode_next = 1'b0;
                        state_next = ST_INV_SQ;
                    end
                end
            end
            ST_DIV:
            begin
                // Sigmoid: |s|*ONE / (ONE+|s|), sign applied afterwards.
                sabs = (acc_reg < 0) ? -64'(acc_reg) : 64'(acc_reg);
                div_start = 1'b1;
                div_dividend = 48'(sabs <<< FRAC_BITS);
                div_divisor = 33'(ONE + sabs);
                state_next = ST_SIG_DONE;
            end
            ST_SIG_DONE:
            begin
                if (div_done)
                begin
                    act_next = (acc_reg < 0) ? -$signed(32'(div_q)) : $signed(32'(div_q));
                    acc_next = '0;
                    res_next.kind = KIND_OUTPUT;
                    res_next.out_slot = '0;
                    res_next.result = act_next;
                    state_next = ST_EMIT;
                end
            end
            ST_INV_SQ:
            begin
                // inv = ONE*ONE/(ONE+|o|).
                sabs = (act_reg < 0) ? -64'(act_reg) : 64'(act_reg);
                if (!sig_mode_reg)
                begin
                    div_start = 1'b1;
                    div_dividend = 48'(ONE <<< FRAC_BITS);
                    div_divisor = 33'(ONE + sabs);
                    sig_mode_next = 1'b1;
                end
                else if (div_done)
                begin
                    mul_go = 1'b1;
                    ma = 33'(div_q);
                    mb = 33'(div_q);
                    state_next = ST_GRAD_MUL;
                end
            end
            ST_GRAD_MUL:
            begin
                if (!mul_go_reg)
                begin
                    mul_go = 1'b1;
                    ma = 33'(ta_reg);
                    mb = 33'(prod_reg);
                    state_next = ST_GRAD_DONE;
                end
            end
            ST_GRAD_DONE:
            begin
                if (!mul_go_reg)
                begin
                    grad_next = prod_reg;
                    res_next.kind = KIND_GRADIENT;
                    res_next.out_slot = '0;
                    res_next.result = prod_reg;
                    state_next = ST_EMIT;
                end
            end
            ST_UPD_M2:
            begin
                // Second product waits for eta*x.
                if (!mul_go_reg)
                begin
                    mul_go = 1'b1;
                    ma = 33'(prod_reg);
                    mb = 33'(grad_reg);
                    state_next = ST_UPD_M3;
                end
            end
            ST_UPD_M3:
            begin
                if (!mul_go_reg)
                begin
                    ta_next = prod_reg;
                    mul_go = 1'b1;
                    ma = {16'd0, momentum};
                    mb = 33'(d_rd_reg);
                    state_next = ST_UPD_SUM;
                end
            end
            ST_UPD_SUM:
            begin
                if (!mul_go_reg)
                begin
                    tb_next = sat32(64'(ta_reg) + 64'(prod_reg));
                    ta_next = sat32(64'(w_rd_reg) + 64'(tb_next));
                    res_next.kind = KIND_WEIGHT;
                    res_next.out_slot = cmd_reg.slot;
                    res_next.result = ta_next;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                mem_wr = (cmd_reg.op == FUNC_UPDATE);
                res_valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        ta_reg <= ta_next;
        tb_reg <= tb_next;
        res_reg <= res_next;
    end

    // Control and neuron state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            acc_reg <= '0;
            act_reg <= '0;
            grad_reg <= '0;
            sig_mode_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            clr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg <= acc_next;
            act_reg <= act_next;
            grad_reg <= grad_next;
            sig_mode_reg <= sig_mode_next;
            res_valid_reg <= res_valid_next;
            if (clearing)
            begin
                clr_reg <= clr_reg + {{AW{1'b0}}, 1'b1};
            end
        end
    end
endmodule
`default_nettype wire

[sv/neuron_backprop_unit.sv]
// Top level of the backpropagation neuron with momentum learning.
// Usage:
// - Input queue: an item transaction happens when push is high and full is
//   low. Items carry func, slot, value, link_weight and last.
// - Result queue: while empty is low the oldest result is on out_item; a
//   transaction happens when pop is high and empty is low.
// - Configuration: cfg_valid/cfg_ready write learn_rate (index 0) or
//   momentum (index 1); cfg_ready is always high.
// - A front part queues up to two commands, a back part executes them on one
//   shared 33x33 multiplier and a one-bit-per-cycle divider.
// - Forward and hidden-gradient elements each use the multiplier once; updates
//   use it for eta*x*grad and the momentum term; a run end adds a division for
//   the forward sigmoid and a division plus the multiplier for gradients.
// - After reset the weight, change and input memories are cleared entry by
//   entry, and no item is executed until that is done.
// - If the receiver does not pop, the back part holds the single result and
//   stops; the input queue fills and raises full.
`default_nettype none
module neuron_backprop_unit #(
    parameter int FAN_IN    = nbu_pkg::FAN_IN_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire nbu_pkg::in_item_t  in_item,
    output logic                    empty,
    input  wire logic               pop,
    output nbu_pkg::out_item_t      out_item,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [16:0]        cfg_data
);
    import nbu_pkg::*;

    logic [16:0] learn_rate_reg, momentum_reg;
    logic        cmd_valid, cmd_take, res_valid;
    cmd_t        cmd;

    assign cfg_ready = 1'b1;
    assign empty = !res_valid;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg <= LEARN_RATE_RST;
            momentum_reg <= MOMENTUM_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LEARN_RATE: learn_rate_reg <= cfg_data;
                CFG_MOMENTUM:   momentum_reg <= cfg_data;
                default:        learn_rate_reg <= learn_rate_reg;
            endcase
        end
    end

    nbu_front #(.FAN_IN(FAN_IN)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    nbu_back #(.FAN_IN(FAN_IN)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_take   (cmd_take),
        .learn_rate (learn_rate_reg),
        .momentum   (momentum_reg),
        .res_valid  (res_valid),
        .res        (out_item),
        .res_taken  (pop)
    );
endmodule
`default_nettype wire
